### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. The checks are compiled for simulation
// and drop out when SYNTHESIS is defined. Each macro expects the enclosing
// module to have a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define LFU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Field widths, operation codes and controller state codes for the
// LFU cache policy block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Payload field widths.
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CAP_CFG_W = 5;

    // Capacity register value after reset.
    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

endpackage

### hw/rtl/lfu_in_if.sv
// ----------------------------------------------------------------------------
// lfu_in_if
// Request channel: one get or put of a key per transfer.
// ----------------------------------------------------------------------------
interface lfu_in_if;

    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [lfu_pkg::KEY_W-1:0]        lookup_key;
    logic signed [lfu_pkg::VAL_W-1:0] write_value;

    modport source (
        output valid,
        output mode,
        output lookup_key,
        output write_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  lookup_key,
        input  write_value,
        output ready
    );

endinterface

### hw/rtl/lfu_out_if.sv
// ----------------------------------------------------------------------------
// lfu_out_if
// Response channel: one result per request transfer.
// ----------------------------------------------------------------------------
interface lfu_out_if;

    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic signed [lfu_pkg::VAL_W-1:0] read_value;
    logic                             evicted;
    logic [lfu_pkg::KEY_W-1:0]        evicted_key;

    modport source (
        output valid,
        output hit,
        output read_value,
        output evicted,
        output evicted_key,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit,
        input  read_value,
        input  evicted,
        input  evicted_key,
        output ready
    );

endinterface

### hw/rtl/lfu_cache_policy.sv
// ----------------------------------------------------------------------------
// lfu_cache_policy
// Key-value table with least-frequently-used replacement and oldest-stamp
// tie break. Requests arrive on in_ch (get or put of a key), one response
// per request leaves on out_ch. The capacity register limits the number of
// entries in use before a put of a new key evicts one.
//
// An accepted request moves from IDLE to SCAN and then to WRITE, where its
// response is registered for out_ch. One request is in work at a time, and the
// next request is taken only once the block is back in IDLE. The pace is set by
// the scan of the entry memory, which has a single read port and is read one
// entry per cycle to find the key, a free slot and the victim.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits. If the receiver stalls, the block holds
// the next finished response (and its table update) until out_ch is free.
// After reset the block sweeps every entry of the memory to clear the
// valid flags; in_ch.ready stays low during that pass. Capacity writes are
// taken at any time and must only occur while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_cache_policy #(
    parameter int CAPACITY   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lfu_pkg::CAP_CFG_W-1:0]   cfg_wr_data,
    lfu_in_if.sink                          in_ch,
    lfu_out_if.source                       out_ch
);

    // Address, scan counter and occupancy widths.
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SZ_W  = (CNT_W > lfu_pkg::CAP_CFG_W) ? CNT_W : lfu_pkg::CAP_CFG_W;
    localparam logic [AW-1:0]   LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [SZ_W-1:0] CAP_SZ   = SZ_W'(CAPACITY);

    typedef struct packed {
        logic                        valid;
        logic [lfu_pkg::KEY_W-1:0]   key;
        logic [lfu_pkg::VAL_W-1:0]   value;
        logic [COUNT_BITS-1:0]       count;
        logic [lfu_pkg::STAMP_W-1:0] stamp;
    } entry_t;

    // Entry memory and its registered read port.
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;
    logic   rd_en;
    logic [AW-1:0] rd_addr;
    logic   mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t mem_wdata;

    // Control state.
    lfu_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   issue_idx_reg, issue_idx_next;
    logic            issue_done_reg, issue_done_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [lfu_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [lfu_pkg::CAP_CFG_W-1:0] capacity_reg, capacity_next;
    logic            out_vld_reg, out_vld_next;

    // Scan accumulators.
    logic [CNT_W-1:0] used_reg, used_next;
    logic             found_vld_reg, found_vld_next;
    logic             free_vld_reg, free_vld_next;
    logic             vic_vld_reg, vic_vld_next;
    logic [AW-1:0]    found_idx_reg, found_idx_next;
    logic [lfu_pkg::VAL_W-1:0] found_val_reg, found_val_next;
    logic [COUNT_BITS-1:0]     found_cnt_reg, found_cnt_next;
    logic [AW-1:0]    free_idx_reg, free_idx_next;
    logic [AW-1:0]    vic_idx_reg, vic_idx_next;
    logic [COUNT_BITS-1:0]       vic_cnt_reg, vic_cnt_next;
    logic [lfu_pkg::STAMP_W-1:0] vic_stamp_reg, vic_stamp_next;
    logic [lfu_pkg::KEY_W-1:0]   vic_key_reg, vic_key_next;

    // Captured request.
    logic                      mode_reg, mode_next;
    logic [lfu_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lfu_pkg::VAL_W-1:0] wval_reg, wval_next;

    // Output payload registers.
    logic                      out_hit_reg, out_hit_next;
    logic [lfu_pkg::VAL_W-1:0] out_rval_reg, out_rval_next;
    logic                      out_evicted_reg, out_evicted_next;
    logic [lfu_pkg::KEY_W-1:0] out_ekey_reg, out_ekey_next;

    // Combinational decision signals.
    logic                      in_xfer;
    logic                      scan_step;
    logic                      step_match;
    logic                      step_vic;
    logic                      step_free;
    logic                      out_free;
    logic                      commit;
    logic [SZ_W-1:0]           cap_ext;
    logic [SZ_W-1:0]           limit;
    logic                      evict;
    logic                      res_hit;
    logic [lfu_pkg::VAL_W-1:0] res_rval;
    logic                      res_evicted;
    logic [lfu_pkg::KEY_W-1:0] res_ekey;
    logic                      wr_req;
    logic [AW-1:0]             wr_slot;
    entry_t                    wr_entry;
    logic [COUNT_BITS-1:0]     cnt_inc;

    // Handshake outputs.
    assign in_ch.ready        = (state_reg == lfu_pkg::ST_IDLE);
    assign in_xfer            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_vld_reg;
    assign out_ch.hit         = out_hit_reg;
    assign out_ch.read_value  = $signed(out_rval_reg);
    assign out_ch.evicted     = out_evicted_reg;
    assign out_ch.evicted_key = out_ekey_reg;

    // Memory read port: one entry per scan cycle.
    assign rd_en   = (state_reg == lfu_pkg::ST_SCAN) && !issue_done_reg;
    assign rd_addr = issue_idx_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Memory write port: clearing pass or the single update of a request.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Compare the entry that came back from memory against the running picks.
    always_comb
    begin
        scan_step  = (state_reg == lfu_pkg::ST_SCAN) && rd_vld_reg;
        step_match = rd_data_reg.valid && !found_vld_reg && (rd_data_reg.key == key_reg);
        step_vic   = rd_data_reg.valid &&
                     (!vic_vld_reg ||
                      (rd_data_reg.count < vic_cnt_reg) ||
                      ((rd_data_reg.count == vic_cnt_reg) &&
                       (rd_data_reg.stamp < vic_stamp_reg)));
        step_free  = !rd_data_reg.valid && !free_vld_reg;
    end

    // Decide the response and the table update once the scan is complete.
    always_comb
    begin
        cap_ext     = SZ_W'(capacity_reg);
        limit       = (cap_ext > CAP_SZ) ? CAP_SZ : cap_ext;
        evict       = (SZ_W'(used_reg) >= limit) && vic_vld_reg;
        cnt_inc     = (&found_cnt_reg) ? found_cnt_reg : found_cnt_reg + COUNT_BITS'(1);
        res_hit     = 1'b0;
        res_rval    = '0;
        res_evicted = 1'b0;
        res_ekey    = '0;
        wr_req      = 1'b0;
        wr_slot     = found_idx_reg;
        wr_entry.valid = 1'b1;
        wr_entry.key   = key_reg;
        wr_entry.value = wval_reg;
        wr_entry.count = COUNT_BITS'(1);
        wr_entry.stamp = stamp_reg;
        priority if (found_vld_reg)
        begin
            // Present key: bump the count, renew the stamp, maybe new value.
            res_hit        = 1'b1;
            res_rval       = (mode_reg == lfu_pkg::MODE_GET) ? found_val_reg : '0;
            wr_req         = 1'b1;
            wr_entry.value = (mode_reg == lfu_pkg::MODE_PUT) ? wval_reg : found_val_reg;
            wr_entry.count = cnt_inc;
        end
        else if ((mode_reg == lfu_pkg::MODE_GET) || (limit == '0))
        begin
            // Get miss, or a put while the table has no room at all.
        end
        else
        begin
            // Put miss: take the victim's slot when full, else a free one.
            res_evicted = evict;
            res_ekey    = evict ? vic_key_reg : '0;
            wr_req      = evict || free_vld_reg;
            wr_slot     = evict ? vic_idx_reg : free_idx_reg;
        end
    end

    // The response register must be free before a request is finished.
    assign out_free = !out_vld_reg || out_ch.ready;
    assign commit   = (state_reg == lfu_pkg::ST_WRITE) && out_free;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_slot;
        mem_wdata = wr_entry;
        if (state_reg == lfu_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (commit && wr_req)
        begin
            mem_we = 1'b1;
        end
    end

    // Next-state logic of the sequencer and its accumulators.
    always_comb
    begin
        state_next       = state_reg;
        issue_idx_next   = issue_idx_reg;
        issue_done_next  = issue_done_reg;
        rd_vld_next      = rd_en;
        rd_idx_next      = rd_en ? issue_idx_reg : rd_idx_reg;
        clr_idx_next     = clr_idx_reg;
        stamp_next       = stamp_reg;
        capacity_next    = cfg_wr_en ? cfg_wr_data : capacity_reg;
        out_vld_next     = out_vld_reg;
        used_next        = used_reg;
        found_vld_next   = found_vld_reg;
        free_vld_next    = free_vld_reg;
        vic_vld_next     = vic_vld_reg;
        found_idx_next   = found_idx_reg;
        found_val_next   = found_val_reg;
        found_cnt_next   = found_cnt_reg;
        free_idx_next    = free_idx_reg;
        vic_idx_next     = vic_idx_reg;
        vic_cnt_next     = vic_cnt_reg;
        vic_stamp_next   = vic_stamp_reg;
        vic_key_next     = vic_key_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        wval_next        = wval_reg;
        out_hit_next     = out_hit_reg;
        out_rval_next    = out_rval_reg;
        out_evicted_next = out_evicted_reg;
        out_ekey_next    = out_ekey_reg;

        // A waiting response leaves when the receiver takes it.
        if (out_vld_reg && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            lfu_pkg::ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            lfu_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next       = in_ch.mode;
                    key_next        = in_ch.lookup_key;
                    wval_next       = in_ch.write_value;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    used_next       = '0;
                    found_vld_next  = 1'b0;
                    free_vld_next   = 1'b0;
                    vic_vld_next    = 1'b0;
                    state_next      = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                // Issue side: walk the addresses once.
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + AW'(1);
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                // Compare side: fold in the entry read the cycle before.
                if (scan_step)
                begin
                    if (rd_data_reg.valid)
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                    if (step_match)
                    begin
                        found_vld_next = 1'b1;
                        found_idx_next = rd_idx_reg;
                        found_val_next = rd_data_reg.value;
                        found_cnt_next = rd_data_reg.count;
                    end
                    if (step_vic)
                    begin
                        vic_vld_next   = 1'b1;
                        vic_idx_next   = rd_idx_reg;
                        vic_cnt_next   = rd_data_reg.count;
                        vic_stamp_next = rd_data_reg.stamp;
                        vic_key_next   = rd_data_reg.key;
                    end
                    if (step_free)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = lfu_pkg::ST_WRITE;
                    end
                end
            end
            lfu_pkg::ST_WRITE:
            begin
                if (commit)
                begin
                    out_vld_next     = 1'b1;
                    out_hit_next     = res_hit;
                    out_rval_next    = res_rval;
                    out_evicted_next = res_evicted;
                    out_ekey_next    = res_ekey;
                    if (wr_req)
                    begin
                        stamp_next = stamp_reg + lfu_pkg::STAMP_W'(1);
                    end
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfu_pkg::ST_CLEAR;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            clr_idx_reg    <= '0;
            stamp_reg      <= '0;
            capacity_reg   <= lfu_pkg::CAP_RESET;
            out_vld_reg    <= 1'b0;
            used_reg       <= '0;
            found_vld_reg  <= 1'b0;
            free_vld_reg   <= 1'b0;
            vic_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            clr_idx_reg    <= clr_idx_next;
            stamp_reg      <= stamp_next;
            capacity_reg   <= capacity_next;
            out_vld_reg    <= out_vld_next;
            used_reg       <= used_next;
            found_vld_reg  <= found_vld_next;
            free_vld_reg   <= free_vld_next;
            vic_vld_reg    <= vic_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        found_idx_reg   <= found_idx_next;
        found_val_reg   <= found_val_next;
        found_cnt_reg   <= found_cnt_next;
        free_idx_reg    <= free_idx_next;
        vic_idx_reg     <= vic_idx_next;
        vic_cnt_reg     <= vic_cnt_next;
        vic_stamp_reg   <= vic_stamp_next;
        vic_key_reg     <= vic_key_next;
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        wval_reg        <= wval_next;
        out_hit_reg     <= out_hit_next;
        out_rval_reg    <= out_rval_next;
        out_evicted_reg <= out_evicted_next;
        out_ekey_reg    <= out_ekey_next;
    end

    // Memory writes happen only in the clearing pass or when finishing.
    `LFU_ASSERT(a_we_state, mem_we |-> ((state_reg == lfu_pkg::ST_WRITE) || (state_reg == lfu_pkg::ST_CLEAR)), "memory write outside clear or write state")
    // No read data may be in flight when a new request can be taken.
    `LFU_ASSERT_NEVER(a_idle_rd, in_ch.ready && rd_vld_reg, "stale read data while idle")
    // The stamp moves only when an entry is written for a request.
    `LFU_ASSERT(a_stamp_hold, !(commit && wr_req) |=> $stable(stamp_reg), "stamp changed without an update")
    // A response never reports both a hit and an eviction.
    `LFU_ASSERT_NEVER(a_hit_evict, out_vld_reg && out_hit_reg && out_evicted_reg, "hit and eviction in one response")

endmodule
